>>> rtl/fac_pkg.sv
// shared types and constants for the fully associative fifo-replacement cache model
// no dependencies; imported by every module of the block
`default_nettype none

package fac_pkg;

  // default geometry, used as the defaults of the top level parameters
  localparam int unsigned DEF_ENTRIES    = 32;
  localparam int unsigned DEF_ADDR_WIDTH = 32;

  // widths fixed by the interface
  localparam int unsigned CMD_WIDTH = 2;
  localparam int unsigned CNT_WIDTH = 32;

  // depth of the queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // access command codes
  localparam logic [CMD_WIDTH-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_STORE = 2'd1;

  // access kind after classification
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_STORE,
    KIND_OTHER
  } kind_e;

  // request head presented by the front end to the back end
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } req_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/fac_front.sv
// front end: accepts accesses, classifies the command and queues them
// depends on fac_pkg
`default_nettype none

module fac_front #(
  parameter int unsigned ADDR_WIDTH = fac_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [fac_pkg::CMD_WIDTH-1:0]  cmd_i,
  input  wire logic [ADDR_WIDTH-1:0]          address_i,
  output fac_pkg::req_ctrl_t                  req_o,
  output logic [ADDR_WIDTH-1:0]               req_address_o,
  input  wire logic                           req_pop_i
);
  import fac_pkg::*;

  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  kind_e                   kind_q [QUEUE_DEPTH];
  logic [ADDR_WIDTH-1:0]   addr_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       count_q, count_d;
  logic                    push;
  kind_e                   in_kind;

  // command classification
  always_comb begin
    unique case (cmd_i)
      CMD_LOAD:  in_kind = KIND_LOAD;
      CMD_STORE: in_kind = KIND_STORE;
      default:   in_kind = KIND_OTHER;
    endcase
  end

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (req_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !req_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && req_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q] <= in_kind;
      addr_q[wr_ptr_q] <= address_i;
    end
  end

  assign req_o.valid   = (count_q != '0);
  assign req_o.kind    = kind_q[rd_ptr_q];
  assign req_address_o = addr_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/fac_back.sv
// back end: tag lookup, fill or fifo eviction, running counters, result register
// depends on fac_pkg
`default_nettype none

module fac_back #(
  parameter int unsigned ENTRIES    = fac_pkg::DEF_ENTRIES,
  parameter int unsigned ADDR_WIDTH = fac_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned SLOT_W     = $clog2(ENTRIES)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fac_pkg::req_ctrl_t             req_i,
  input  wire logic [ADDR_WIDTH-1:0]          req_address_i,
  output logic                                req_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                hit_o,
  output logic [SLOT_W-1:0]                   slot_o,
  output logic                                evicted_o,
  output logic [ADDR_WIDTH-1:0]               evicted_address_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       load_total_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       store_total_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       load_hit_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       load_miss_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       store_hit_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       store_miss_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       access_count_o
);
  import fac_pkg::*;

  localparam int unsigned FILL_W = $clog2(ENTRIES + 1);

  logic [ADDR_WIDTH-1:0]  tag_q [ENTRIES];
  logic [FILL_W-1:0]      fill_cnt_q;
  logic [SLOT_W-1:0]      victim_q;

  logic [ENTRIES-1:0]     hit_vec;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_slot;
  logic                   store_full;
  logic [SLOT_W-1:0]      miss_slot;
  logic [SLOT_W-1:0]      acc_slot;

  logic                   out_valid_q;
  logic                   hit_q;
  logic [SLOT_W-1:0]      slot_q;
  logic                   evicted_q;
  logic [ADDR_WIDTH-1:0]  evict_addr_q;
  logic [CNT_WIDTH-1:0]   load_total_q, store_total_q;
  logic [CNT_WIDTH-1:0]   load_hit_q, load_miss_q;
  logic [CNT_WIDTH-1:0]   store_hit_q, store_miss_q;
  logic [CNT_WIDTH-1:0]   access_q;

  // valid entries always form a prefix, so the fill count stands in for valid bits
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = (FILL_W'(i) < fill_cnt_q) && (tag_q[i] == req_address_i);
    end
  end

  // lowest matching entry
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // fifo order of a fill-only cache is the slot order, so a round-robin pointer is the head
  assign store_full = (fill_cnt_q == FILL_W'(ENTRIES));
  assign miss_slot  = store_full ? victim_q : fill_cnt_q[SLOT_W-1:0];
  assign acc_slot   = hit ? hit_slot : miss_slot;

  assign req_pop_o  = req_i.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (req_pop_o && !hit) begin
      tag_q[miss_slot] <= req_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
      victim_q   <= '0;
    end else if (req_pop_o && !hit) begin
      if (store_full) begin
        victim_q <= (victim_q == SLOT_W'(ENTRIES - 1)) ? '0 : victim_q + 1'b1;
      end else begin
        fill_cnt_q <= fill_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      hit_q        <= hit;
      slot_q       <= acc_slot;
      evicted_q    <= !hit && store_full;
      evict_addr_q <= (!hit && store_full) ? tag_q[victim_q] : '0;
    end
  end

  // counters change only when a new result is loaded, so they are the result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_total_q  <= '0;
      store_total_q <= '0;
      load_hit_q    <= '0;
      load_miss_q   <= '0;
      store_hit_q   <= '0;
      store_miss_q  <= '0;
      access_q      <= '0;
    end else if (req_pop_o) begin
      access_q <= access_q + 1'b1;
      unique case (req_i.kind)
        KIND_LOAD: begin
          load_total_q <= load_total_q + 1'b1;
          if (hit) begin
            load_hit_q <= load_hit_q + 1'b1;
          end else begin
            load_miss_q <= load_miss_q + 1'b1;
          end
        end
        KIND_STORE: begin
          store_total_q <= store_total_q + 1'b1;
          if (hit) begin
            store_hit_q <= store_hit_q + 1'b1;
          end else begin
            store_miss_q <= store_miss_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign slot_o             = slot_q;
  assign evicted_o          = evicted_q;
  assign evicted_address_o  = evict_addr_q;
  assign load_total_o       = load_total_q;
  assign store_total_o      = store_total_q;
  assign load_hit_count_o   = load_hit_q;
  assign load_miss_count_o  = load_miss_q;
  assign store_hit_count_o  = store_hit_q;
  assign store_miss_count_o = store_miss_q;
  assign access_count_o     = access_q;

endmodule

`default_nettype wire

>>> rtl/fully_assoc_cache_fifo_replace_unit.sv
// top level of the fully associative cache hit/miss model with fifo replacement
// depends on fac_pkg, fac_front and fac_back
`default_nettype none

// Hit/miss model of a fully associative cache with ENTRIES entries and fifo
// replacement. Each item carries a command (load, store, other) and an address
// that is the whole tag. The block returns one result item per access: hit,
// the slot that matched or was filled, whether a valid tag was evicted and
// which one, plus the running load/store/hit/miss/access counters including
// this access (all wrapping at 32 bits). The front end classifies the command
// and holds up to two items in a small queue; the back end does the parallel
// tag compare, the fill or eviction and the counter update as it pops the
// queue head, and loads the output register. Throughput is one item per cycle
// while the result channel does not stall, set by that lookup-and-update loop
// in the back end; an accepted item passes the queue register and then the
// output register; a stalled result holds the queue head back. Tags live in
// flops and need no clearing pass after reset, so items are accepted at once.

module fully_assoc_cache_fifo_replace_unit #(
  parameter int unsigned ENTRIES    = fac_pkg::DEF_ENTRIES,
  parameter int unsigned ADDR_WIDTH = fac_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned SLOT_W     = $clog2(ENTRIES)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // access channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [fac_pkg::CMD_WIDTH-1:0]  cmd_i,
  input  wire logic [ADDR_WIDTH-1:0]          address_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                hit_o,
  output logic [SLOT_W-1:0]                   slot_o,
  output logic                                evicted_o,
  output logic [ADDR_WIDTH-1:0]               evicted_address_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       load_total_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       store_total_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       load_hit_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       load_miss_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       store_hit_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       store_miss_count_o,
  output logic [fac_pkg::CNT_WIDTH-1:0]       access_count_o
);
  import fac_pkg::*;

  // queue head handed from front to back
  req_ctrl_t              req;
  logic [ADDR_WIDTH-1:0]  req_address;
  logic                   req_pop;

  // front end: command classification and input queue
  fac_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .address_i     (address_i),
    .req_o         (req),
    .req_address_o (req_address),
    .req_pop_i     (req_pop)
  );

  // back end: lookup, replacement, counters and result register
  fac_back #(
    .ENTRIES    (ENTRIES),
    .ADDR_WIDTH (ADDR_WIDTH),
    .SLOT_W     (SLOT_W)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_i              (req),
    .req_address_i      (req_address),
    .req_pop_o          (req_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_o              (hit_o),
    .slot_o             (slot_o),
    .evicted_o          (evicted_o),
    .evicted_address_o  (evicted_address_o),
    .load_total_o       (load_total_o),
    .store_total_o      (store_total_o),
    .load_hit_count_o   (load_hit_count_o),
    .load_miss_count_o  (load_miss_count_o),
    .store_hit_count_o  (store_hit_count_o),
    .store_miss_count_o (store_miss_count_o),
    .access_count_o     (access_count_o)
  );

endmodule

`default_nettype wire

>>> rtl/fac_checker.sv
// port-level checks for the fully associative fifo-replacement cache model
// depends on fac_pkg; bound to fully_assoc_cache_fifo_replace_unit below
`default_nettype none

module fac_checker #(
  parameter int unsigned ADDR_WIDTH = fac_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned SLOT_W     = $clog2(fac_pkg::DEF_ENTRIES)
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          hit_o,
  input wire logic [SLOT_W-1:0]             slot_o,
  input wire logic                          evicted_o,
  input wire logic [ADDR_WIDTH-1:0]         evicted_address_o,
  input wire logic [fac_pkg::CNT_WIDTH-1:0] load_total_o,
  input wire logic [fac_pkg::CNT_WIDTH-1:0] store_total_o,
  input wire logic [fac_pkg::CNT_WIDTH-1:0] load_hit_count_o,
  input wire logic [fac_pkg::CNT_WIDTH-1:0] load_miss_count_o,
  input wire logic [fac_pkg::CNT_WIDTH-1:0] store_hit_count_o,
  input wire logic [fac_pkg::CNT_WIDTH-1:0] store_miss_count_o
);
  import fac_pkg::*;

  logic [CNT_WIDTH-1:0] load_sum;
  logic [CNT_WIDTH-1:0] store_sum;

  assign load_sum  = load_hit_count_o + load_miss_count_o;
  assign store_sum = store_hit_count_o + store_miss_count_o;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) && $stable(hit_o))
    else $error("stalled result changed");

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o)
    else $error("hit reported an eviction");

  // no eviction means a zero evicted tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_address_o == '0)
    else $error("evicted tag nonzero without eviction");

  // every load and store is either a hit or a miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (load_sum == load_total_o) && (store_sum == store_total_o))
    else $error("hit and miss counts do not add up to totals");

endmodule

bind fully_assoc_cache_fifo_replace_unit fac_checker #(
  .ADDR_WIDTH (ADDR_WIDTH),
  .SLOT_W     (SLOT_W)
) u_fac_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .hit_o              (hit_o),
  .slot_o             (slot_o),
  .evicted_o          (evicted_o),
  .evicted_address_o  (evicted_address_o),
  .load_total_o       (load_total_o),
  .store_total_o      (store_total_o),
  .load_hit_count_o   (load_hit_count_o),
  .load_miss_count_o  (load_miss_count_o),
  .store_hit_count_o  (store_hit_count_o),
  .store_miss_count_o (store_miss_count_o)
);

`default_nettype wire

>>> test/fully_assoc_cache_fifo_replace_unit_test.sv
// self-checking testbench for the fully associative fifo-replacement cache unit
// holds its own cache model, random idling on both channels; depends on fac_pkg and the unit
`default_nettype none

module fully_assoc_cache_fifo_replace_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fac_pkg::*;

  localparam int unsigned NUM_LINES  = 32;
  localparam int unsigned IDLE_LIMIT = 3000;

  // command codes the package leaves unnamed
  localparam logic [CMD_WIDTH-1:0] CMD_OTHER = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_SPARE = 2'd3;

  // one result item as the unit reports it
  typedef struct packed {
    logic                 hit;
    logic [4:0]           slot;
    logic                 evicted;
    logic [31:0]          evicted_address;
    logic [CNT_WIDTH-1:0] load_total;
    logic [CNT_WIDTH-1:0] store_total;
    logic [CNT_WIDTH-1:0] load_hits;
    logic [CNT_WIDTH-1:0] load_misses;
    logic [CNT_WIDTH-1:0] store_hits;
    logic [CNT_WIDTH-1:0] store_misses;
    logic [CNT_WIDTH-1:0] accesses;
  } access_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CMD_WIDTH-1:0] cmd_i = CMD_LOAD;
  logic [31:0]          address_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hit_o;
  logic [4:0]           slot_o;
  logic                 evicted_o;
  logic [31:0]          evicted_address_o;
  logic [CNT_WIDTH-1:0] load_total_o;
  logic [CNT_WIDTH-1:0] store_total_o;
  logic [CNT_WIDTH-1:0] load_hit_count_o;
  logic [CNT_WIDTH-1:0] load_miss_count_o;
  logic [CNT_WIDTH-1:0] store_hit_count_o;
  logic [CNT_WIDTH-1:0] store_miss_count_o;
  logic [CNT_WIDTH-1:0] access_count_o;

  fully_assoc_cache_fifo_replace_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .address_i          (address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_o              (hit_o),
    .slot_o             (slot_o),
    .evicted_o          (evicted_o),
    .evicted_address_o  (evicted_address_o),
    .load_total_o       (load_total_o),
    .store_total_o      (store_total_o),
    .load_hit_count_o   (load_hit_count_o),
    .load_miss_count_o  (load_miss_count_o),
    .store_hit_count_o  (store_hit_count_o),
    .store_miss_count_o (store_miss_count_o),
    .access_count_o     (access_count_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cache model: tags, valid bits, fifo of fill order and the running counters
  // ---------------------------------------------------------------------------
  logic [31:0]          line_tag [NUM_LINES];
  logic [NUM_LINES-1:0] line_valid = '0;
  logic [4:0]           fill_order [NUM_LINES];
  logic [4:0]           order_head = 5'd0;
  logic [4:0]           order_tail = 5'd31;
  logic [CNT_WIDTH-1:0] n_loads = '0, n_stores = '0, n_accesses = '0;
  logic [CNT_WIDTH-1:0] n_load_hits = '0, n_load_misses = '0;
  logic [CNT_WIDTH-1:0] n_store_hits = '0, n_store_misses = '0;

  access_result_t expected_results[$];
  int unsigned    mismatch_count = 0;

  // looks the address up, fills or evicts, and returns what the unit must report
  function automatic access_result_t cache_lookup(logic [CMD_WIDTH-1:0] cmd,
                                                  logic [31:0] addr);
    access_result_t r;
    bit             found;
    bit             filled;
    r = '0;
    found = 1'b0;
    filled = 1'b0;
    if (cmd == CMD_LOAD) n_loads++;
    else if (cmd == CMD_STORE) n_stores++;

    // parallel compare, lowest matching slot wins
    for (int i = 0; i < NUM_LINES; i++) begin
      if (!found && line_valid[i] && line_tag[i] == addr) begin
        found = 1'b1;
        r.slot = i[4:0];
      end
    end

    if (!found) begin
      // lowest free slot first
      for (int i = 0; i < NUM_LINES; i++) begin
        if (!filled && !line_valid[i]) begin
          filled = 1'b1;
          r.slot = i[4:0];
        end
      end
      // all full: replace the oldest fill
      if (!filled) begin
        r.slot = fill_order[order_head];
        order_head++;
        r.evicted = 1'b1;
        r.evicted_address = line_tag[r.slot];
      end
      line_tag[r.slot] = addr;
      line_valid[r.slot] = 1'b1;
      order_tail++;
      fill_order[order_tail] = r.slot;
      if (cmd == CMD_LOAD) n_load_misses++;
      else if (cmd == CMD_STORE) n_store_misses++;
    end else begin
      if (cmd == CMD_LOAD) n_load_hits++;
      else if (cmd == CMD_STORE) n_store_hits++;
    end
    n_accesses++;

    r.hit = found;
    r.load_total = n_loads;
    r.store_total = n_stores;
    r.load_hits = n_load_hits;
    r.load_misses = n_load_misses;
    r.store_hits = n_store_hits;
    r.store_misses = n_store_misses;
    r.accesses = n_accesses;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // idling on both channels
  // ---------------------------------------------------------------------------
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stall pattern, same shape as the sender gaps
  always @(posedge clk_i) begin : stall_gen
    int unsigned r;
    int unsigned stall_left;
    if (!stall_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_stall_i <= 1'b0;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest pending expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string field_name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%08h, got 0x%08h", $time, field_name, exp_val, act_val);
    end
  endtask

  // outputs are sampled at the edge before the unit updates them
  always @(posedge clk_i) begin : result_check
    access_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item with no access pending, expected none, got slot %0d",
                 $time, slot_o);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("hit", 32'(exp_r.hit), 32'(hit_o));
        check_field("slot", 32'(exp_r.slot), 32'(slot_o));
        check_field("evicted", 32'(exp_r.evicted), 32'(evicted_o));
        check_field("evicted_address", exp_r.evicted_address, evicted_address_o);
        check_field("load_total", exp_r.load_total, load_total_o);
        check_field("store_total", exp_r.store_total, store_total_o);
        check_field("load_hit_count", exp_r.load_hits, load_hit_count_o);
        check_field("load_miss_count", exp_r.load_misses, load_miss_count_o);
        check_field("store_hit_count", exp_r.store_hits, store_hit_count_o);
        check_field("store_miss_count", exp_r.store_misses, store_miss_count_o);
        check_field("access_count", exp_r.accesses, access_count_o);
      end
    end
  end

  // watchdog: too long without any item moving on either channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one access; valid stays high across back-to-back items
  task automatic send_access(logic [CMD_WIDTH-1:0] cmd, logic [31:0] addr);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(cache_lookup(cmd, addr));
  endtask

  // sender holds off until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // field extremes, every command including the spare code, hits of every kind
  task automatic test_directed_accesses();
    send_access(CMD_LOAD, 32'h0000_0000);   // cold miss into slot 0
    send_access(CMD_LOAD, 32'h0000_0000);   // load hit
    send_access(CMD_STORE, 32'hFFFF_FFFF);  // store miss, slot 1
    send_access(CMD_STORE, 32'hFFFF_FFFF);  // store hit
    send_access(CMD_OTHER, 32'h0000_0000);  // other hits, no per-kind count
    send_access(CMD_SPARE, 32'hFFFF_FFFF);  // spare code acts like other
    send_access(CMD_SPARE, 32'h1234_5678);  // spare code still fills
    send_access(CMD_OTHER, 32'hA5A5_A5A5);
    send_access(CMD_LOAD, 32'h5A5A_5A5A);
    send_access(CMD_STORE, 32'h0000_0000);
    send_access(CMD_LOAD, 32'hFFFF_FFFF);
    send_access(CMD_STORE, 32'h8000_0000);
    send_access(CMD_LOAD, 32'h0000_0001);
    send_access(CMD_LOAD, 32'h8000_0000);
    send_access(CMD_OTHER, 32'h0000_0001);
    send_access(CMD_STORE, 32'h1234_5678);
    send_access(CMD_LOAD, 32'hA5A5_A5A5);
    send_access(CMD_SPARE, 32'h7FFF_FFFF);
  endtask

  // working set drawn from a pool; pool size sets the hit and eviction mix
  task automatic test_random_traffic(int unsigned n_items, int unsigned pool_size);
    logic [31:0]          addr_pool [64];
    logic [CMD_WIDTH-1:0] cmd;
    logic [31:0]          addr;
    int unsigned          r;
    for (int i = 0; i < 64; i++) addr_pool[i] = $urandom;
    for (int unsigned n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) cmd = CMD_LOAD;
      else if (r < 75) cmd = CMD_STORE;
      else if (r < 92) cmd = CMD_OTHER;
      else cmd = CMD_SPARE;
      // occasional churn of the working set and some stray addresses
      if ($urandom_range(0, 99) < 5) addr_pool[$urandom_range(0, pool_size - 1)] = $urandom;
      if ($urandom_range(0, 99) < 15) addr = $urandom;
      else addr = addr_pool[$urandom_range(0, pool_size - 1)];
      send_access(cmd, addr);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_accesses();
    drain_results();

    // working set a bit above capacity: hits, fills and evictions
    test_random_traffic(200, 40);
    drain_results();

    // small working set at full rate, no idling either side
    idle_on = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(120, 12);
    idle_on = 1'b1;
    stall_on = 1'b1;
    drain_results();

    // working set twice the capacity: mostly evictions
    test_random_traffic(160, 64);
    drain_results();

    // results still in flight would show up here as unexpected
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
